@@ rtl/ppc_pkg.sv @@
// Package for the polygon pair collision unit.
// Holds default sizes, operation codes, polygon select codes, the sequencer state type and edge-test status.
// No dependencies.
`default_nettype none

package ppc_pkg;

	// default sizes handed to the top level parameters
	localparam int unsigned MaxVerticesDef = 64;
	localparam int unsigned CoordBitsDef   = 16;

	// item operation codes
	localparam logic OpLoad  = 1'b0;
	localparam logic OpCheck = 1'b1;

	// polygon select on a vertex load
	localparam logic PolyA = 1'b0;
	localparam logic PolyB = 1'b1;

	// check sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CIRC_SQ,
		ST_CIRC_CMP,
		ST_ROW,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} ppc_state_t;

	// status from the edge pair pipeline
	typedef struct packed {
		logic busy;
		logic hit_valid;
		logic hit;
	} ppc_edge_stat_t;

endpackage

`default_nettype wire

@@ rtl/ppc_item_if.sv @@
// Input channel of the polygon pair collision unit: one vertex load or one check per beat.
// Depends on ppc_pkg for the default coordinate width.
`default_nettype none

interface ppc_item_if
	import ppc_pkg::*;
#(
	parameter int unsigned COORD_BITS = CoordBitsDef
);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic                         which_polygon;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic signed [COORD_BITS-1:0] center_a_x;
	logic signed [COORD_BITS-1:0] center_a_y;
	logic        [COORD_BITS-1:0] radius_a;
	logic signed [COORD_BITS-1:0] center_b_x;
	logic signed [COORD_BITS-1:0] center_b_y;
	logic        [COORD_BITS-1:0] radius_b;

	modport source (
		output valid, operation, which_polygon, vertex_x, vertex_y,
		output center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
		input  ready
	);

	modport sink (
		input  valid, operation, which_polygon, vertex_x, vertex_y,
		input  center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/ppc_result_if.sv @@
// Result channel of the polygon pair collision unit: one beat per check.
// No dependencies.
`default_nettype none

interface ppc_result_if;
	logic valid;
	logic ready;
	logic collided;
	logic circles_overlap;

	modport source (
		output valid, collided, circles_overlap,
		input  ready
	);

	modport sink (
		input  valid, collided, circles_overlap,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/ppc_edge_test.sv @@
// Pipelined segment intersection test: one edge pair in per cycle, verdict registered through stages 1, 2 and 3.
// Depends on ppc_pkg for the status struct and the default coordinate width.
`default_nettype none

module ppc_edge_test
	import ppc_pkg::*;
#(
	parameter int unsigned COORD_BITS = CoordBitsDef
)
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] dx,
	input  logic signed [COORD_BITS-1:0] dy,
	output ppc_edge_stat_t               stat
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * COORD_BITS + 2;
	localparam int unsigned VW = 2 * COORD_BITS + 3;

	// true when r lies inside the bounding box of segment p-q
	function automatic logic in_box(
		input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py,
		input logic signed [COORD_BITS-1:0] qx,
		input logic signed [COORD_BITS-1:0] qy,
		input logic signed [COORD_BITS-1:0] rx,
		input logic signed [COORD_BITS-1:0] ry
	);
		logic okx;
		logic oky;
		okx = ((px <= rx) && (rx <= qx)) || ((qx <= rx) && (rx <= px));
		oky = ((py <= ry) && (ry <= qy)) || ((qy <= ry) && (ry <= py));
		return okx && oky;
	endfunction

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [DW-1:0] acx_s1, acy_s1, bcx_s1, bcy_s1, dcx_s1, dcy_s1;
	logic signed [DW-1:0] cax_s1, cay_s1, bax_s1, bay_s1, dax_s1, day_s1;
	logic [3:0]           box_s1, box_s2, box_s3;
	logic signed [PW-1:0] pl_s2 [4];
	logic signed [PW-1:0] pr_s2 [4];
	logic signed [VW-1:0] turn_v [4];
	logic [3:0]           pos_s3, neg_s3, zero_s3;
	logic                 s12, s34;

	// advance the valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: end point differences and bounding box tests
	always_ff @(posedge clk) begin
		acx_s1 <= DW'(ax) - DW'(cx);
		acy_s1 <= DW'(ay) - DW'(cy);
		bcx_s1 <= DW'(bx) - DW'(cx);
		bcy_s1 <= DW'(by) - DW'(cy);
		dcx_s1 <= DW'(dx) - DW'(cx);
		dcy_s1 <= DW'(dy) - DW'(cy);
		cax_s1 <= DW'(cx) - DW'(ax);
		cay_s1 <= DW'(cy) - DW'(ay);
		bax_s1 <= DW'(bx) - DW'(ax);
		bay_s1 <= DW'(by) - DW'(ay);
		dax_s1 <= DW'(dx) - DW'(ax);
		day_s1 <= DW'(dy) - DW'(ay);
		box_s1[0] <= in_box(cx, cy, dx, dy, ax, ay);
		box_s1[1] <= in_box(cx, cy, dx, dy, bx, by);
		box_s1[2] <= in_box(ax, ay, bx, by, cx, cy);
		box_s1[3] <= in_box(ax, ay, bx, by, dx, dy);
	end

	// stage 2: the eight cross product terms
	always_ff @(posedge clk) begin
		pl_s2[0] <= acx_s1 * dcy_s1;
		pr_s2[0] <= dcx_s1 * acy_s1;
		pl_s2[1] <= bcx_s1 * dcy_s1;
		pr_s2[1] <= dcx_s1 * bcy_s1;
		pl_s2[2] <= cax_s1 * bay_s1;
		pr_s2[2] <= bax_s1 * cay_s1;
		pl_s2[3] <= dax_s1 * bay_s1;
		pr_s2[3] <= bax_s1 * day_s1;
		box_s2   <= box_s1;
	end

	// stage 3: orientation signs
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			turn_v[k] = VW'(pl_s2[k]) - VW'(pr_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			zero_s3[k] <= (turn_v[k] == '0);
			neg_s3[k]  <= turn_v[k][VW-1];
			pos_s3[k]  <= !turn_v[k][VW-1] && (turn_v[k] != '0);
		end
		box_s3 <= box_s2;
	end

	// proper crossing, or an end point on the other segment
	assign s12 = (pos_s3[0] && neg_s3[1]) || (neg_s3[0] && pos_s3[1]);
	assign s34 = (pos_s3[2] && neg_s3[3]) || (neg_s3[2] && pos_s3[3]);

	assign stat.hit       = (s12 && s34) || (|(zero_s3 & box_s3));
	assign stat.hit_valid = valid_s3;
	assign stat.busy      = valid_s1 || valid_s2 || valid_s3;

endmodule

`default_nettype wire

@@ rtl/polygon_pair_collision_unit.sv @@
// Polygon pair collision unit: two vertex stores, a bounding-circle pre-check and an
// edge pair sweep. Depends on ppc_pkg, ppc_item_if, ppc_result_if and ppc_edge_test.
`default_nettype none

// A vertex load gives no result; loads past MAX_VERTICES per polygon are dropped. A check
// skips the sweep when the bounding circles are separated or either polygon is empty.
// Otherwise the sweep reads one polygon b vertex from its store per cycle and issues one
// edge pair per cycle, pausing in ST_ROW at each polygon a edge to fetch its next vertex.
// The sweep stops early once the pipeline reports a touching pair. Loads are taken only
// while no check is in progress; a finished result waits in the output register while new
// loads are taken. Both vertex counts clear when a check posts its result to the output
// register.
module polygon_pair_collision_unit
	import ppc_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = MaxVerticesDef,
	parameter int unsigned COORD_BITS   = CoordBitsDef
)
(
	input  logic         clk,
	input  logic         arst_n,
	ppc_item_if.sink     item,
	ppc_result_if.source result
);

	localparam int unsigned AW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned VB = 2 * COORD_BITS;
	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned SW = 2 * COORD_BITS + 2;
	localparam logic [CW-1:0] MaxCount = CW'(MAX_VERTICES);

	ppc_state_t state_q, state_d;

	// vertex stores, {y, x} per entry
	logic [VB-1:0] a_mem [MAX_VERTICES];
	logic [VB-1:0] b_mem [MAX_VERTICES];
	logic [VB-1:0] a_rd_q, b_rd_q;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] i_q, j_q, i_next, j_next, j_plus2;
	logic [VB-1:0] a_first_q, b_first_q, ai_q, bprev_q;
	logic [VB-1:0] ak, b_start, b_end, vtx;
	logic          last_a, last_b;

	logic signed [DW-1:0] cdx_q, cdy_q;
	logic        [DW-1:0] rs_q;
	logic signed [SW-1:0] dx2_q, dy2_q;
	logic        [SW-1:0] rs2_q;
	logic        [SW:0]   d2;
	logic                 overlap_now;
	logic                 overlap_q, hit_q;
	logic                 out_valid_q, collided_q, overlap_out_q;

	logic          item_fire, load_fire, check_fire, wr_a, wr_b, out_free;
	logic          ctl_ready, rd_a_en, rd_b_en, issue;
	logic [AW-1:0] a_addr, b_addr;

	ppc_edge_stat_t stat;

	// handshake decode
	assign item_fire  = item.valid && item.ready;
	assign load_fire  = item_fire && (item.operation == OpLoad);
	assign check_fire = item_fire && (item.operation == OpCheck);
	assign wr_a = load_fire && (item.which_polygon == PolyA) && (cnt_a_q < MaxCount);
	assign wr_b = load_fire && (item.which_polygon == PolyB) && (cnt_b_q < MaxCount);
	assign vtx  = {item.vertex_y, item.vertex_x};
	assign out_free = !out_valid_q || result.ready;

	// sweep indexes and edge end points
	assign i_next  = i_q + CW'(1);
	assign j_next  = j_q + CW'(1);
	assign j_plus2 = j_q + CW'(2);
	assign last_a  = (i_next == cnt_a_q);
	assign last_b  = (j_next == cnt_b_q);
	assign ak      = last_a ? a_first_q : a_rd_q;
	assign b_start = (j_q == '0) ? b_first_q : bprev_q;
	assign b_end   = last_b ? b_first_q : b_rd_q;
	assign a_addr  = i_next[AW-1:0];
	assign b_addr  = (state_q == ST_ROW) ? AW'(1) : j_plus2[AW-1:0];

	// circle separation: compare squared radius sum with squared distance
	assign d2          = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign overlap_now = !({1'b0, rs2_q} < d2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (check_fire) state_d = ST_CIRC_SQ;
			end
			ST_CIRC_SQ: begin
				state_d = ST_CIRC_CMP;
			end
			ST_CIRC_CMP: begin
				if (overlap_now && (cnt_a_q != '0) && (cnt_b_q != '0)) state_d = ST_ROW;
				else state_d = ST_DONE;
			end
			ST_ROW: begin
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (hit_q) state_d = ST_DRAIN;
				else if (last_b) state_d = last_a ? ST_DRAIN : ST_ROW;
			end
			ST_DRAIN: begin
				if (!stat.busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ctl_ready = 1'b0;
		rd_a_en   = 1'b0;
		rd_b_en   = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: ctl_ready = 1'b1;
			ST_ROW: begin
				rd_a_en = 1'b1;
				rd_b_en = 1'b1;
			end
			ST_SWEEP: begin
				rd_b_en = 1'b1;
				issue   = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			hit_q       <= 1'b0;
			overlap_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_a) cnt_a_q <= cnt_a_q + CW'(1);
			if (wr_b) cnt_b_q <= cnt_b_q + CW'(1);
			if (check_fire) begin
				i_q   <= '0;
				j_q   <= '0;
				hit_q <= 1'b0;
			end else if (stat.hit_valid && stat.hit) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_CIRC_CMP) overlap_q <= overlap_now;
			// step the inner index, wrap to the next polygon a edge
			if (state_q == ST_SWEEP) begin
				j_q <= last_b ? '0 : j_next;
				if (last_b) i_q <= i_next;
			end
			// post the result, drop both counts
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				cnt_a_q     <= '0;
				cnt_b_q     <= '0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (wr_a && cnt_a_q == '0) a_first_q <= vtx;
		if (wr_b && cnt_b_q == '0) b_first_q <= vtx;
		if (check_fire) begin
			cdx_q <= DW'(item.center_b_x) - DW'(item.center_a_x);
			cdy_q <= DW'(item.center_b_y) - DW'(item.center_a_y);
			rs_q  <= DW'(item.radius_a) + DW'(item.radius_b);
		end
		if (state_q == ST_CIRC_SQ) begin
			dx2_q <= cdx_q * cdx_q;
			dy2_q <= cdy_q * cdy_q;
			rs2_q <= SW'(rs_q) * SW'(rs_q);
		end
		if (state_q == ST_CIRC_CMP) ai_q <= a_first_q;
		if (state_q == ST_SWEEP) begin
			bprev_q <= b_rd_q;
			if (last_b) ai_q <= ak;
		end
		if (state_q == ST_DONE && out_free) begin
			collided_q    <= hit_q && overlap_q;
			overlap_out_q <= overlap_q;
		end
	end

	// vertex stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_a) a_mem[cnt_a_q[AW-1:0]] <= vtx;
		if (rd_a_en) a_rd_q <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b) b_mem[cnt_b_q[AW-1:0]] <= vtx;
		if (rd_b_en) b_rd_q <= b_mem[b_addr];
	end

	// edge pair pipeline
	ppc_edge_test #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (issue),
		.ax     (ai_q[COORD_BITS-1:0]),
		.ay     (ai_q[VB-1:COORD_BITS]),
		.bx     (ak[COORD_BITS-1:0]),
		.by     (ak[VB-1:COORD_BITS]),
		.cx     (b_start[COORD_BITS-1:0]),
		.cy     (b_start[VB-1:COORD_BITS]),
		.dx     (b_end[COORD_BITS-1:0]),
		.dy     (b_end[VB-1:COORD_BITS]),
		.stat   (stat)
	);

	// port drive
	assign item.ready             = ctl_ready;
	assign result.valid           = out_valid_q;
	assign result.collided        = collided_q;
	assign result.circles_overlap = overlap_out_q;

	// no collision is reported with separated circles
	a_hit_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.circles_overlap || !result.collided))
		else $error("collision reported with separated circles");

	// every issued pair lies within the loaded outlines
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ((i_q < cnt_a_q) && (j_q < cnt_b_q)))
		else $error("edge pair issued beyond the vertex counts");

	// the pipeline is empty when a result is posted
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !stat.busy)
		else $error("result posted with edge pairs in flight");

	// both counts clear once a check completes
	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (cnt_a_q == '0 && cnt_b_q == '0))
		else $error("vertex counts not cleared after a check");

endmodule

`default_nettype wire
